[src/xo_pkg.sv]
// shared types, constants and helpers for the xoshiro256++ generator
package xo_pkg;

   localparam int WORD_W     = 64;
   localparam int HALF_W     = 32;
   localparam int OP_W       = 2;
   localparam int FRAC_W     = 53;
   localparam int FRAC_SHIFT = 11;
   localparam int GEN_DEPTH  = 4;
   localparam int IDX_W      = 2;
   localparam int PHASE_W    = 2;

   // splitmix64 constants
   localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94D049BB133111EB;
   localparam int MIX_SHIFT_1 = 30;
   localparam int MIX_SHIFT_2 = 27;
   localparam int MIX_SHIFT_3 = 31;

   // xoshiro256++ rotate and shift amounts
   localparam int ROT_RES   = 23;
   localparam int ROT_STATE = 45;
   localparam int SHL_STATE = 17;

   // last entry of the state array
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GEN_DEPTH - 1);

   // partial product phases of one 64-bit low-half multiply
   localparam logic [PHASE_W-1:0] PH_LO_LO = 2'd0;
   localparam logic [PHASE_W-1:0] PH_LO_HI = 2'd1;
   localparam logic [PHASE_W-1:0] PH_HI_LO = 2'd2;
   localparam logic [PHASE_W-1:0] PH_ACC   = 2'd3;

   typedef enum logic [OP_W-1:0] {
      OP_NEXT = 2'd0,
      OP_SEED = 2'd1,
      OP_HASH = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      MIX_IDLE,
      MIX_STAGE_A,
      MIX_STAGE_B
   } mix_state_type;

   typedef enum logic [1:0] {
      TOP_SEED,
      TOP_IDLE,
      TOP_HASH,
      TOP_HOLD
   } top_state_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] value;
   } mix_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] result;
   } mix_rsp_type;

   // rotate left by a constant amount
   function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v, input int amt);
      rot_left = (v << amt) | (v >> (WORD_W - amt));
   endfunction

endpackage

[src/xo_req_if.sv]
// request channel: operation and seed value
interface xo_req_if;
   import xo_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [WORD_W-1:0] seed_value;

   modport source (output valid, output operation, output seed_value, input ready);
   modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

[src/xo_rsp_if.sv]
// response channel: random word and its fraction
interface xo_rsp_if;
   import xo_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] random_word;
   logic [FRAC_W-1:0] uniform_fraction;

   modport source (output valid, output random_word, output uniform_fraction, input ready);
   modport sink   (input valid, input random_word, input uniform_fraction, output ready);
endinterface

[src/xo_mul.sv]
// shared 32x32 multiplier with registered product
module xo_mul (
   input  logic                        clock,
   input  logic [xo_pkg::HALF_W-1:0]   mul_a,
   input  logic [xo_pkg::HALF_W-1:0]   mul_b,
   output logic [xo_pkg::WORD_W-1:0]   prod
);
   import xo_pkg::*;

   logic [WORD_W-1:0] prod_ff;

   // one partial product per cycle
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;
endmodule

[src/xo_mix.sv]
// splitmix64 sequencer around the shared multiplier
module xo_mix (
   input  logic                clock,
   input  logic                reset,
   input  xo_pkg::mix_req_type mix_req,
   output xo_pkg::mix_rsp_type mix_rsp
);
   import xo_pkg::*;

   mix_state_type      state_ff, state_in;
   logic [PHASE_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]  opnd_ff, opnd_in;
   logic [WORD_W-1:0]  acc_ff, acc_in;
   logic [WORD_W-1:0]  res_ff, res_in;
   logic               done_ff, done_in;

   logic [HALF_W-1:0]  mul_a, mul_b;
   logic [WORD_W-1:0]  prod;
   logic [WORD_W-1:0]  mul_const;
   logic [WORD_W-1:0]  addend;
   logic [WORD_W-1:0]  sum_c;
   logic [WORD_W-1:0]  seed_sum;
   logic               last;

   xo_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // constant for the current multiply
   assign mul_const = (state_ff == MIX_STAGE_B) ? MIX_MUL_B : MIX_MUL_A;

   // operand halves per phase
   always_comb begin
      case (cnt_ff)
         PH_LO_HI: begin
            mul_a = opnd_ff[HALF_W-1:0];
            mul_b = mul_const[WORD_W-1:HALF_W];
         end
         PH_HI_LO: begin
            mul_a = opnd_ff[WORD_W-1:HALF_W];
            mul_b = mul_const[HALF_W-1:0];
         end
         default: begin
            mul_a = opnd_ff[HALF_W-1:0];
            mul_b = mul_const[HALF_W-1:0];
         end
      endcase
   end

   // accumulate the product issued in the previous phase
   always_comb begin
      case (cnt_ff)
         PH_LO_HI: addend = prod;
         PH_HI_LO: addend = {prod[HALF_W-1:0], {HALF_W{1'b0}}};
         PH_ACC:   addend = {prod[HALF_W-1:0], {HALF_W{1'b0}}};
         default:  addend = '0;
      endcase
   end

   assign sum_c    = acc_ff + addend;
   assign last     = (cnt_ff == PH_ACC);
   assign seed_sum = mix_req.value + GOLDEN_INC;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MIX_IDLE:    if (mix_req.start) state_in = MIX_STAGE_A;
         MIX_STAGE_A: if (last) state_in = MIX_STAGE_B;
         MIX_STAGE_B: if (last) state_in = MIX_IDLE;
         default:     state_in = MIX_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      cnt_in  = '0;
      opnd_in = opnd_ff;
      acc_in  = sum_c;
      res_in  = res_ff;
      done_in = 1'b0;
      case (state_ff)
         MIX_IDLE: begin
            acc_in = '0;
            if (mix_req.start) begin
               opnd_in = seed_sum ^ (seed_sum >> MIX_SHIFT_1);
            end
         end
         MIX_STAGE_A: begin
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               opnd_in = sum_c ^ (sum_c >> MIX_SHIFT_2);
               acc_in  = '0;
            end
         end
         MIX_STAGE_B: begin
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               res_in  = sum_c ^ (sum_c >> MIX_SHIFT_3);
               done_in = 1'b1;
               acc_in  = '0;
            end
         end
         default: begin
            acc_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MIX_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign mix_rsp.done   = done_ff;
   assign mix_rsp.result = res_ff;
endmodule

[src/xoshiro256pp_generator_top.sv]
// xoshiro256++ generator with splitmix64 seeding and hash
// next: result in the output register in the cycle after the beat, one per cycle while rsp drains
// hash: one splitmix64 round on seed_value; seed: four chained rounds fill state words 0 to 3
// each splitmix64 round takes two 64-bit multiplies on one 32x32 multiplier
// reset seeds the state from a zero seed value with req_bus.ready low
module xoshiro256pp_generator_top (
   input  logic    clock,
   input  logic    reset,
   xo_req_if.sink  req_bus,
   xo_rsp_if.source rsp_bus
);
   import xo_pkg::*;

   top_state_type     state_ff, state_in;
   logic [WORD_W-1:0] gen_ff [GEN_DEPTH];
   logic [WORD_W-1:0] gen_in [GEN_DEPTH];
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              start_ff, start_in;
   logic [WORD_W-1:0] mix_val_ff, mix_val_in;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_word_ff, out_word_in;

   logic              slot_free;
   logic              accept;
   logic [WORD_W-1:0] next_word;
   logic [WORD_W-1:0] t2, t3;
   mix_req_type       mix_req;
   mix_rsp_type       mix_rsp;

   xo_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .mix_req (mix_req),
      .mix_rsp (mix_rsp)
   );

   assign mix_req.start = start_ff;
   assign mix_req.value = mix_val_ff;

   // handshake
   assign slot_free     = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == TOP_IDLE) && slot_free;
   assign accept        = req_bus.valid && req_bus.ready;

   // generator output and state mixing
   assign next_word = rot_left(gen_ff[0] + gen_ff[3], ROT_RES) + gen_ff[0];
   assign t2        = gen_ff[2] ^ gen_ff[0];
   assign t3        = gen_ff[3] ^ gen_ff[1];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TOP_SEED: if (mix_rsp.done && idx_ff == IDX_LAST) state_in = TOP_IDLE;
         TOP_IDLE: begin
            if (accept) begin
               case (req_bus.operation)
                  OP_SEED: state_in = TOP_SEED;
                  OP_HASH: state_in = TOP_HASH;
                  default: state_in = TOP_IDLE;
               endcase
            end
         end
         TOP_HASH: if (mix_rsp.done) state_in = TOP_HOLD;
         TOP_HOLD: if (slot_free) state_in = TOP_IDLE;
         default:  state_in = TOP_IDLE;
      endcase
   end

   // datapath and output register updates
   always_comb begin
      gen_in       = gen_ff;
      idx_in       = idx_ff;
      start_in     = 1'b0;
      mix_val_in   = mix_val_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_word_in  = out_word_ff;
      case (state_ff)
         TOP_SEED: begin
            if (mix_rsp.done) begin
               gen_in[idx_ff] = mix_rsp.result;
               idx_in         = idx_ff + 1'b1;
               if (idx_ff != IDX_LAST) begin
                  mix_val_in = mix_rsp.result;
                  start_in   = 1'b1;
               end
            end
         end
         TOP_IDLE: begin
            if (accept) begin
               case (req_bus.operation)
                  OP_NEXT: begin
                     gen_in[0]    = gen_ff[0] ^ t3;
                     gen_in[1]    = gen_ff[1] ^ t2;
                     gen_in[2]    = t2 ^ (gen_ff[1] << SHL_STATE);
                     gen_in[3]    = rot_left(t3, ROT_STATE);
                     out_word_in  = next_word;
                     out_valid_in = 1'b1;
                  end
                  OP_SEED: begin
                     mix_val_in = req_bus.seed_value;
                     idx_in     = '0;
                     start_in   = 1'b1;
                  end
                  OP_HASH: begin
                     mix_val_in = req_bus.seed_value;
                     start_in   = 1'b1;
                  end
                  default: begin
                     idx_in = idx_ff;
                  end
               endcase
            end
         end
         TOP_HOLD: begin
            if (slot_free) begin
               out_word_in  = mix_rsp.result;
               out_valid_in = 1'b1;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // control registers; reset starts seeding from zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_SEED;
         idx_ff       <= '0;
         start_ff     <= 1'b1;
         mix_val_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         start_ff     <= start_in;
         mix_val_ff   <= mix_val_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      gen_ff      <= gen_in;
      out_word_ff <= out_word_in;
   end

   // response beat
   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.random_word      = out_word_ff;
   assign rsp_bus.uniform_fraction = out_word_ff[WORD_W-1:FRAC_SHIFT];
endmodule
